// File: rtl/ttl_pkg.sv
// template token lexer package: state codes, token kinds, result bundle type
// no dependencies
package ttl_pkg;

  localparam int NumW      = 32;
  localparam int LineW     = 16;
  localparam int KwCount   = 11;
  localparam int MaxRes    = 3;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  typedef enum logic [3:0] {
    ST_TEXT, ST_TEXT_BRACE, ST_CODE, ST_IDENT, ST_NUMBER, ST_STRING, ST_LBRACE,
    ST_RBRACE, ST_DOT, ST_EQ, ST_BANG, ST_LT, ST_GT, ST_AMP, ST_BAR
  } scan_e;

  localparam logic [5:0] K_RUN    = 6'd0;
  localparam logic [5:0] K_DLBR   = 6'd1;
  localparam logic [5:0] K_LBPCT  = 6'd3;
  localparam logic [5:0] K_STREND = 6'd5;
  localparam logic [5:0] K_IDENT  = 6'd6;
  localparam logic [5:0] K_NUM    = 6'd7;
  localparam logic [5:0] K_PLUS   = 6'd8;
  localparam logic [5:0] K_MINUS  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_SLASH  = 6'd11;
  localparam logic [5:0] K_PCT    = 6'd12;
  localparam logic [5:0] K_AND    = 6'd13;
  localparam logic [5:0] K_OR     = 6'd14;
  localparam logic [5:0] K_EQEQ   = 6'd15;
  localparam logic [5:0] K_NE     = 6'd16;
  localparam logic [5:0] K_LT     = 6'd17;
  localparam logic [5:0] K_GT     = 6'd18;
  localparam logic [5:0] K_LE     = 6'd19;
  localparam logic [5:0] K_GE     = 6'd20;
  localparam logic [5:0] K_LPAR   = 6'd21;
  localparam logic [5:0] K_RPAR   = 6'd22;
  localparam logic [5:0] K_LBR    = 6'd24;
  localparam logic [5:0] K_RBR    = 6'd25;
  localparam logic [5:0] K_LSQ    = 6'd26;
  localparam logic [5:0] K_RSQ    = 6'd27;
  localparam logic [5:0] K_RANGE  = 6'd30;
  localparam logic [5:0] K_EOF    = 6'd43;
  localparam logic [5:0] K_ERR    = 6'd44;
  localparam logic [5:0] K_TEXTB  = 6'd45;
  localparam logic [5:0] K_STRB   = 6'd46;
  localparam logic [5:0] K_IDB    = 6'd47;

  typedef struct packed {
    logic [1:0]               n;
    logic [2:0][5:0]          kind;
    logic [2:0][7:0]          tbyte;
    logic [NumW-1:0]          num;
    logic [LineW-1:0]         line;
    logic [LineW-1:0]         errl;
  } bndl_t;

  function automatic bndl_t push_res(bndl_t b, logic [5:0] k, logic [7:0] t);
    bndl_t r;
    r = b;
    if (b.n != 2'd3) begin
      r.kind[b.n]  = k;
      r.tbyte[b.n] = t;
      r.n          = b.n + 2'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/ttl_if.sv
// word channel interfaces of the template token lexer
// depends on ttl_pkg
interface ttl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;
  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface ttl_out_if;
  logic                     valid;
  logic                     ready;
  logic [5:0]               kind;
  logic [7:0]               text_byte;
  logic [ttl_pkg::NumW-1:0]  number_value;
  logic [ttl_pkg::LineW-1:0] line_number;
  logic [ttl_pkg::LineW-1:0] error_line;
  logic                     last;
  modport source (output valid, kind, text_byte, number_value, line_number, error_line, last,
                  input ready);
  modport sink (input valid, kind, text_byte, number_value, line_number, error_line, last,
                output ready);
endinterface

// File: rtl/ttl_front.sv
// front end: per-word scanner state, keyword mask, result bundle builder
// depends on ttl_pkg
module ttl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  input  logic              eoi_i,
  output logic              push_o,
  input  logic              full_i,
  output ttl_pkg::bndl_t    bndl_o
);

  ttl_pkg::scan_e                st_q, st_d;
  logic                          tne_q, tne_d;
  logic [ttl_pkg::KwCount-1:0]   cand_q, cand_d;
  logic [3:0]                    pos_q, pos_d;
  logic [ttl_pkg::NumW-1:0]      acc_q, acc_d;
  logic [ttl_pkg::LineW-1:0]     line_q, line_d;
  logic [ttl_pkg::LineW-1:0]     errl_q, errl_d;
  ttl_pkg::bndl_t                b;
  logic                          fire;
  logic                          do_code;
  logic                          is_let, is_dig;
  logic [ttl_pkg::NumW+3:0]      prod;
  logic [3:0]                    dig;

  function automatic logic [79:0] kw_word(logic [3:0] k);
    logic [79:0] w;
    unique case (k)
      4'd0:    w = "if";
      4'd1:    w = "endif";
      4'd2:    w = "else";
      4'd3:    w = "for";
      4'd4:    w = "in";
      4'd5:    w = "endfor";
      4'd6:    w = "include";
      4'd7:    w = "blockprint";
      4'd8:    w = "menuprint";
      4'd9:    w = "block";
      4'd10:   w = "endblock";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      4'd0, 4'd4: l = 4'd2;
      4'd1, 4'd9: l = 4'd5;
      4'd2:       l = 4'd4;
      4'd3:       l = 4'd3;
      4'd5:       l = 4'd6;
      4'd6:       l = 4'd7;
      4'd7:       l = 4'd10;
      4'd8:       l = 4'd9;
      4'd10:      l = 4'd8;
      default:    l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [5:0] kw_kind(logic [3:0] k);
    logic [5:0] r;
    unique case (k)
      4'd0:    r = 6'd33;
      4'd1:    r = 6'd34;
      4'd2:    r = 6'd35;
      4'd3:    r = 6'd36;
      4'd4:    r = 6'd38;
      4'd5:    r = 6'd37;
      4'd6:    r = 6'd32;
      4'd7:    r = 6'd39;
      4'd8:    r = 6'd40;
      4'd9:    r = 6'd41;
      4'd10:   r = 6'd42;
      default: r = ttl_pkg::K_IDENT;
    endcase
    return r;
  endfunction

  function automatic logic [ttl_pkg::KwCount-1:0] kw_feed(
      logic [ttl_pkg::KwCount-1:0] cand, logic [3:0] pos, logic [7:0] c);
    logic [ttl_pkg::KwCount-1:0] r;
    logic [79:0]                 w;
    logic [3:0]                  l;
    logic [3:0]                  sh;
    r = cand;
    for (int k = 0; k < ttl_pkg::KwCount; k++) begin
      w  = kw_word(4'(k));
      l  = kw_len(4'(k));
      sh = l - 4'd1 - pos;
      if (pos >= l || w[{sh, 3'b000} +: 8] != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] kw_pick(logic [ttl_pkg::KwCount-1:0] cand, logic [3:0] pos);
    logic [5:0] r;
    r = ttl_pkg::K_IDENT;
    for (int k = ttl_pkg::KwCount - 1; k >= 0; k--) begin
      if (cand[k] && kw_len(4'(k)) == pos) r = kw_kind(4'(k));
    end
    return r;
  endfunction

  assign fire       = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign is_let     = (ch_i >= "A" && ch_i <= "Z") || (ch_i >= "a" && ch_i <= "z");
  assign is_dig     = ch_i >= "0" && ch_i <= "9";
  assign dig        = ch_i[3:0];
  assign prod       = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                      {{ttl_pkg::NumW{1'b0}}, dig};

  always_comb begin
    st_d    = st_q;
    tne_d   = tne_q;
    cand_d  = cand_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    line_d  = line_q;
    errl_d  = errl_q;
    do_code = 1'b0;
    b       = '0;
    if (eoi_i) begin
      unique case (st_q)
        ttl_pkg::ST_TEXT_BRACE: begin
          b = ttl_pkg::push_res(b, ttl_pkg::K_TEXTB, "{");
          b = ttl_pkg::push_res(b, ttl_pkg::K_RUN, 8'd0);
        end
        ttl_pkg::ST_TEXT:   if (tne_q) b = ttl_pkg::push_res(b, ttl_pkg::K_RUN, 8'd0);
        ttl_pkg::ST_IDENT:  b = ttl_pkg::push_res(b, kw_pick(cand_q, pos_q), 8'd0);
        ttl_pkg::ST_NUMBER: begin
          b     = ttl_pkg::push_res(b, ttl_pkg::K_NUM, 8'd0);
          b.num = acc_q;
        end
        ttl_pkg::ST_LBRACE: b = ttl_pkg::push_res(b, ttl_pkg::K_LBR, 8'd0);
        ttl_pkg::ST_RBRACE: b = ttl_pkg::push_res(b, ttl_pkg::K_RBR, 8'd0);
        ttl_pkg::ST_LT:     b = ttl_pkg::push_res(b, ttl_pkg::K_LT, 8'd0);
        ttl_pkg::ST_GT:     b = ttl_pkg::push_res(b, ttl_pkg::K_GT, 8'd0);
        ttl_pkg::ST_STRING, ttl_pkg::ST_DOT, ttl_pkg::ST_EQ, ttl_pkg::ST_BANG,
        ttl_pkg::ST_AMP, ttl_pkg::ST_BAR: b = ttl_pkg::push_res(b, ttl_pkg::K_ERR, 8'd0);
        default: ;
      endcase
      b = ttl_pkg::push_res(b, ttl_pkg::K_EOF, 8'd0);
    end else begin
      if (ch_i == 8'd10 && line_q != '1) line_d = line_q + 1'b1;
      unique case (st_q)
        ttl_pkg::ST_TEXT: begin
          if (ch_i == "{") st_d = ttl_pkg::ST_TEXT_BRACE;
          else begin
            b     = ttl_pkg::push_res(b, ttl_pkg::K_TEXTB, ch_i);
            tne_d = 1'b1;
          end
        end
        ttl_pkg::ST_TEXT_BRACE: begin
          if (ch_i == "{") begin
            if (tne_q) b = ttl_pkg::push_res(b, ttl_pkg::K_RUN, 8'd0);
            tne_d = 1'b0;
            st_d  = ttl_pkg::ST_CODE;
          end else begin
            b     = ttl_pkg::push_res(b, ttl_pkg::K_TEXTB, "{");
            b     = ttl_pkg::push_res(b, ttl_pkg::K_TEXTB, ch_i);
            tne_d = 1'b1;
            st_d  = ttl_pkg::ST_TEXT;
          end
        end
        ttl_pkg::ST_IDENT: begin
          if (is_let || is_dig || ch_i == "_") begin
            b      = ttl_pkg::push_res(b, ttl_pkg::K_IDB, ch_i);
            cand_d = kw_feed(cand_q, pos_q, ch_i);
            if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
          end else begin
            b       = ttl_pkg::push_res(b, kw_pick(cand_q, pos_q), 8'd0);
            do_code = 1'b1;
          end
        end
        ttl_pkg::ST_NUMBER: begin
          if (is_dig) begin
            acc_d = (prod[ttl_pkg::NumW+3:ttl_pkg::NumW] != 4'd0) ? '1
                                                                   : prod[ttl_pkg::NumW-1:0];
          end else begin
            b       = ttl_pkg::push_res(b, ttl_pkg::K_NUM, 8'd0);
            b.num   = acc_q;
            acc_d   = '0;
            do_code = 1'b1;
          end
        end
        ttl_pkg::ST_STRING: begin
          if (ch_i == "\"") begin
            b    = ttl_pkg::push_res(b, ttl_pkg::K_STREND, 8'd0);
            st_d = ttl_pkg::ST_CODE;
          end else b = ttl_pkg::push_res(b, ttl_pkg::K_STRB, ch_i);
        end
        ttl_pkg::ST_LBRACE: begin
          b = ttl_pkg::push_res(b, (ch_i == "{") ? ttl_pkg::K_DLBR :
                                   (ch_i == "%") ? ttl_pkg::K_LBPCT : ttl_pkg::K_LBR, 8'd0);
          st_d = ttl_pkg::ST_CODE;
        end
        ttl_pkg::ST_RBRACE: begin
          if (ch_i == "}") begin
            tne_d = 1'b0;
            st_d  = ttl_pkg::ST_TEXT;
          end else begin
            b       = ttl_pkg::push_res(b, ttl_pkg::K_RBR, 8'd0);
            do_code = 1'b1;
          end
        end
        ttl_pkg::ST_DOT: begin
          b    = ttl_pkg::push_res(b, (ch_i == ".") ? ttl_pkg::K_RANGE : ttl_pkg::K_ERR, 8'd0);
          st_d = ttl_pkg::ST_CODE;
        end
        ttl_pkg::ST_EQ, ttl_pkg::ST_BANG, ttl_pkg::ST_LT, ttl_pkg::ST_GT: begin
          if (ch_i == "=") begin
            b = ttl_pkg::push_res(b, (st_q == ttl_pkg::ST_EQ) ? ttl_pkg::K_EQEQ :
                                     (st_q == ttl_pkg::ST_BANG) ? ttl_pkg::K_NE :
                                     (st_q == ttl_pkg::ST_LT) ? ttl_pkg::K_LE : ttl_pkg::K_GE,
                                  8'd0);
            st_d = ttl_pkg::ST_CODE;
          end else begin
            b = ttl_pkg::push_res(b, (st_q == ttl_pkg::ST_LT) ? ttl_pkg::K_LT :
                                     (st_q == ttl_pkg::ST_GT) ? ttl_pkg::K_GT : ttl_pkg::K_ERR,
                                  8'd0);
            do_code = 1'b1;
          end
        end
        ttl_pkg::ST_AMP, ttl_pkg::ST_BAR: begin
          if ((st_q == ttl_pkg::ST_AMP && ch_i == "&") ||
              (st_q == ttl_pkg::ST_BAR && ch_i == "|")) begin
            b = ttl_pkg::push_res(b, (st_q == ttl_pkg::ST_AMP) ? ttl_pkg::K_AND : ttl_pkg::K_OR,
                                  8'd0);
            st_d = ttl_pkg::ST_CODE;
          end else begin
            b       = ttl_pkg::push_res(b, ttl_pkg::K_ERR, 8'd0);
            do_code = 1'b1;
          end
        end
        default: do_code = 1'b1;
      endcase

      // plain code character
      if (do_code) begin
        st_d = ttl_pkg::ST_CODE;
        if (ch_i <= 8'd32) begin
        end else if (is_dig) begin
          acc_d = {{(ttl_pkg::NumW-4){1'b0}}, dig};
          st_d  = ttl_pkg::ST_NUMBER;
        end else if (is_let) begin
          cand_d = kw_feed('1, 4'd0, ch_i);
          pos_d  = 4'd1;
          b      = ttl_pkg::push_res(b, ttl_pkg::K_IDB, ch_i);
          st_d   = ttl_pkg::ST_IDENT;
        end else begin
          case (ch_i)
            ".":  st_d = ttl_pkg::ST_DOT;
            "{":  st_d = ttl_pkg::ST_LBRACE;
            "}":  st_d = ttl_pkg::ST_RBRACE;
            "&":  st_d = ttl_pkg::ST_AMP;
            "|":  st_d = ttl_pkg::ST_BAR;
            "<":  st_d = ttl_pkg::ST_LT;
            ">":  st_d = ttl_pkg::ST_GT;
            "=":  st_d = ttl_pkg::ST_EQ;
            "!":  st_d = ttl_pkg::ST_BANG;
            "\"": st_d = ttl_pkg::ST_STRING;
            "[":  b = ttl_pkg::push_res(b, ttl_pkg::K_LSQ, 8'd0);
            "]":  b = ttl_pkg::push_res(b, ttl_pkg::K_RSQ, 8'd0);
            "(":  b = ttl_pkg::push_res(b, ttl_pkg::K_LPAR, 8'd0);
            ")":  b = ttl_pkg::push_res(b, ttl_pkg::K_RPAR, 8'd0);
            "-":  b = ttl_pkg::push_res(b, ttl_pkg::K_MINUS, 8'd0);
            "+":  b = ttl_pkg::push_res(b, ttl_pkg::K_PLUS, 8'd0);
            "*":  b = ttl_pkg::push_res(b, ttl_pkg::K_STAR, 8'd0);
            "/":  b = ttl_pkg::push_res(b, ttl_pkg::K_SLASH, 8'd0);
            "%":  b = ttl_pkg::push_res(b, ttl_pkg::K_PCT, 8'd0);
            default: begin
              b = ttl_pkg::push_res(b, ttl_pkg::K_ERR, 8'd0);
              if (errl_q == '0) errl_d = line_d;
            end
          endcase
        end
      end
    end
    b.line = line_d;
    b.errl = errl_d;
    if (eoi_i) begin
      st_d   = ttl_pkg::ST_TEXT;
      tne_d  = 1'b0;
      cand_d = '1;
      pos_d  = 4'd0;
      acc_d  = '0;
      line_d = {{(ttl_pkg::LineW-1){1'b0}}, 1'b1};
      errl_d = '0;
    end
  end

  assign push_o = fire && (b.n != 2'd0);
  assign bndl_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ttl_pkg::ST_TEXT;
      tne_q  <= 1'b0;
      cand_q <= '1;
      pos_q  <= 4'd0;
      acc_q  <= '0;
      line_q <= {{(ttl_pkg::LineW-1){1'b0}}, 1'b1};
      errl_q <= '0;
    end else if (fire) begin
      st_q   <= st_d;
      tne_q  <= tne_d;
      cand_q <= cand_d;
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      line_q <= line_d;
      errl_q <= errl_d;
    end
  end

endmodule

// File: rtl/ttl_fifo.sv
// result bundle queue between scanner front and result back end
// depends on ttl_pkg
module ttl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttl_pkg::bndl_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ttl_pkg::bndl_t rdata_o
);

  ttl_pkg::bndl_t               mem_q [ttl_pkg::FifoDepth];
  logic [ttl_pkg::FifoAw-1:0]   wp_q, rp_q;
  logic [ttl_pkg::FifoAw:0]     cnt_q;

  assign full_o  = cnt_q == (ttl_pkg::FifoAw+1)'(ttl_pkg::FifoDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (ttl_pkg::FifoAw+1)'(push_i) - (ttl_pkg::FifoAw+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (ttl_pkg::FifoAw+1)'(ttl_pkg::FifoDepth)) else $error("queue count out of range");
  a_nonempty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rdata_o.n != 2'd0) else $error("empty bundle queued");

endmodule

// File: rtl/ttl_back.sv
// back end: walks the head bundle and hands out one result word per handshake
// depends on ttl_pkg
module ttl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  ttl_pkg::bndl_t            bndl_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [5:0]                kind_o,
  output logic [7:0]                text_byte_o,
  output logic [ttl_pkg::NumW-1:0]  number_value_o,
  output logic [ttl_pkg::LineW-1:0] line_number_o,
  output logic [ttl_pkg::LineW-1:0] error_line_o,
  output logic                      last_o
);

  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o    = valid_i;
  assign take           = valid_i && out_ready_i;
  assign last_o         = idx_q == bndl_i.n - 2'd1;
  assign pop_o          = take && last_o;
  assign kind_o         = bndl_i.kind[idx_q];
  assign text_byte_o    = bndl_i.tbyte[idx_q];
  assign number_value_o = (kind_o == ttl_pkg::K_NUM) ? bndl_i.num : '0;
  assign line_number_o  = bndl_i.line;
  assign error_line_o   = bndl_i.errl;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) idx_d = 2'd0;
    else if (take) idx_d = idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else idx_q <= idx_d;
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> idx_q < bndl_i.n) else $error("result index past bundle");
  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> idx_q == 2'd0) else $error("index not cleared");
  a_pop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0) else $error("index not cleared after pop");

endmodule

// File: rtl/template_token_lexer_top.sv
// template token lexer top level: front scanner, bundle queue, result back end
// depends on ttl_pkg, ttl_if, ttl_front, ttl_fifo, ttl_back
//
// channel  dir  word
// in_i     in   ch, end_of_input
// out_o    out  kind, text_byte, number_value, line_number, error_line, last
//
// one input word per cycle; each word yields zero to three result words
// results leave one per cycle while the receiver is ready, from a four-entry bundle queue
// input stalls only when the queue is full
// asynchronous active-low reset, no clearing pass
module template_token_lexer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttl_in_if.sink    in_i,
  ttl_out_if.source out_o
);

  ttl_pkg::bndl_t wbndl, rbndl;
  logic           push, full, pop, qvalid;

  ttl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .ch_i       (in_i.ch),
    .eoi_i      (in_i.end_of_input),
    .push_o     (push),
    .full_i     (full),
    .bndl_o     (wbndl)
  );

  ttl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbndl),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .rdata_o (rbndl)
  );

  ttl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (qvalid),
    .bndl_i         (rbndl),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .kind_o         (out_o.kind),
    .text_byte_o    (out_o.text_byte),
    .number_value_o (out_o.number_value),
    .line_number_o  (out_o.line_number),
    .error_line_o   (out_o.error_line),
    .last_o         (out_o.last)
  );

endmodule

// File: tb/ttl_checker.sv
// template token lexer checker: predicts result words from accepted input words
// depends on ttl_pkg and ttl_if; compares every accepted result word in order
module ttl_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ttl_in_if    in_m,
  ttl_out_if   out_m,
  output int   err_cnt_o,
  output int   pending_o
);

  localparam logic [5:0] K_INCLUDE  = 6'd32;
  localparam logic [5:0] K_IF       = 6'd33;
  localparam logic [5:0] K_ENDIF    = 6'd34;
  localparam logic [5:0] K_ELSE     = 6'd35;
  localparam logic [5:0] K_FOR      = 6'd36;
  localparam logic [5:0] K_ENDFOR   = 6'd37;
  localparam logic [5:0] K_IN       = 6'd38;
  localparam logic [5:0] K_BLKPRINT = 6'd39;
  localparam logic [5:0] K_MENUPRT  = 6'd40;
  localparam logic [5:0] K_BLOCK    = 6'd41;
  localparam logic [5:0] K_ENDBLOCK = 6'd42;
  localparam logic [31:0] NUM_SAT   = 32'hFFFF_FFFF;

  typedef struct {
    logic [5:0]  kind;
    logic [7:0]  tb;
    logic [31:0] num;
    logic [15:0] ln;
    logic [15:0] el;
    logic        last;
  } tok_t;

  string      kw_word [ttl_pkg::KwCount] = '{"if", "endif", "else", "for", "in", "endfor",
                                    "include", "blockprint", "menuprint", "block",
                                    "endblock"};
  logic [5:0] kw_kind [ttl_pkg::KwCount] = '{K_IF, K_ENDIF, K_ELSE, K_FOR, K_IN, K_ENDFOR,
                                    K_INCLUDE, K_BLKPRINT, K_MENUPRT, K_BLOCK,
                                    K_ENDBLOCK};

  ttl_pkg::scan_e st;
  bit          text_nz;
  bit [10:0]   cand;
  bit [3:0]    id_pos;
  logic [31:0] num_acc;
  logic [15:0] line_cnt;
  logic [15:0] err_line;
  int          n_res;
  logic [5:0]  r_kind [3];
  logic [7:0]  r_byte [3];
  logic [31:0] r_num  [3];
  tok_t        token_q [$];
  int          errs;

  task automatic lexer_reset();
    st       = ttl_pkg::ST_TEXT;
    text_nz  = 0;
    cand     = '1;
    id_pos   = 0;
    num_acc  = 0;
    line_cnt = 16'd1;
    err_line = 0;
  endtask

  task automatic emit(logic [5:0] k, logic [7:0] b, logic [31:0] n);
    if (n_res < 3) begin
      r_kind[n_res] = k;
      r_byte[n_res] = b;
      r_num[n_res]  = n;
      n_res++;
    end
  endtask

  task automatic ident_feed(logic [7:0] c);
    emit(ttl_pkg::K_IDB, c, 0);
    for (int k = 0; k < ttl_pkg::KwCount; k++) begin
      if (id_pos >= kw_word[k].len() || kw_word[k][id_pos] != c) cand[k] = 0;
    end
    if (id_pos < 15) id_pos++;
  endtask

  function automatic logic [5:0] ident_kind();
    for (int k = 0; k < ttl_pkg::KwCount; k++) begin
      if (cand[k] && kw_word[k].len() == id_pos) return kw_kind[k];
    end
    return ttl_pkg::K_IDENT;
  endfunction

  task automatic number_feed(logic [7:0] d);
    if (num_acc > (NUM_SAT - d) / 10) num_acc = NUM_SAT;
    else num_acc = num_acc * 10 + d;
  endtask

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic code_char(logic [7:0] c);
    st = ttl_pkg::ST_CODE;
    if (c <= 8'd32) return;
    if (is_digit(c)) begin
      num_acc = 0;
      number_feed(c - "0");
      st = ttl_pkg::ST_NUMBER;
    end else if (is_letter(c)) begin
      cand   = '1;
      id_pos = 0;
      ident_feed(c);
      st = ttl_pkg::ST_IDENT;
    end else begin
      case (c)
        ".": st = ttl_pkg::ST_DOT;
        "{": st = ttl_pkg::ST_LBRACE;
        "}": st = ttl_pkg::ST_RBRACE;
        "&": st = ttl_pkg::ST_AMP;
        "|": st = ttl_pkg::ST_BAR;
        "<": st = ttl_pkg::ST_LT;
        ">": st = ttl_pkg::ST_GT;
        "=": st = ttl_pkg::ST_EQ;
        "!": st = ttl_pkg::ST_BANG;
        "\"": st = ttl_pkg::ST_STRING;
        "[": emit(ttl_pkg::K_LSQ, 0, 0);
        "]": emit(ttl_pkg::K_RSQ, 0, 0);
        "(": emit(ttl_pkg::K_LPAR, 0, 0);
        ")": emit(ttl_pkg::K_RPAR, 0, 0);
        "-": emit(ttl_pkg::K_MINUS, 0, 0);
        "+": emit(ttl_pkg::K_PLUS, 0, 0);
        "*": emit(ttl_pkg::K_STAR, 0, 0);
        "/": emit(ttl_pkg::K_SLASH, 0, 0);
        "%": emit(ttl_pkg::K_PCT, 0, 0);
        default: begin
          emit(ttl_pkg::K_ERR, 0, 0);
          if (err_line == 0) err_line = line_cnt;
        end
      endcase
    end
  endtask

  task automatic pair(logic [7:0] c, logic [7:0] want, logic [5:0] hit, logic [5:0] miss);
    if (c == want) begin
      emit(hit, 0, 0);
      st = ttl_pkg::ST_CODE;
    end else begin
      emit(miss, 0, 0);
      code_char(c);
    end
  endtask

  task automatic flush_end();
    case (st)
      ttl_pkg::ST_TEXT_BRACE: begin
        emit(ttl_pkg::K_TEXTB, "{", 0);
        emit(ttl_pkg::K_RUN, 0, 0);
      end
      ttl_pkg::ST_TEXT:   if (text_nz) emit(ttl_pkg::K_RUN, 0, 0);
      ttl_pkg::ST_IDENT:  emit(ident_kind(), 0, 0);
      ttl_pkg::ST_NUMBER: emit(ttl_pkg::K_NUM, 0, num_acc);
      ttl_pkg::ST_STRING: emit(ttl_pkg::K_ERR, 0, 0);
      ttl_pkg::ST_LBRACE: emit(ttl_pkg::K_LBR, 0, 0);
      ttl_pkg::ST_RBRACE: emit(ttl_pkg::K_RBR, 0, 0);
      ttl_pkg::ST_LT:     emit(ttl_pkg::K_LT, 0, 0);
      ttl_pkg::ST_GT:     emit(ttl_pkg::K_GT, 0, 0);
      ttl_pkg::ST_DOT, ttl_pkg::ST_EQ, ttl_pkg::ST_BANG, ttl_pkg::ST_AMP,
      ttl_pkg::ST_BAR: emit(ttl_pkg::K_ERR, 0, 0);
      default: ;
    endcase
    emit(ttl_pkg::K_EOF, 0, 0);
  endtask

  task automatic lex_word(logic [7:0] c, logic eoi);
    tok_t t;
    n_res = 0;
    if (eoi) begin
      flush_end();
    end else begin
      if (c == 8'd10 && line_cnt != 16'hFFFF) line_cnt++;
      case (st)
        ttl_pkg::ST_TEXT: begin
          if (c == "{") st = ttl_pkg::ST_TEXT_BRACE;
          else begin
            emit(ttl_pkg::K_TEXTB, c, 0);
            text_nz = 1;
          end
        end
        ttl_pkg::ST_TEXT_BRACE: begin
          if (c == "{") begin
            if (text_nz) emit(ttl_pkg::K_RUN, 0, 0);
            text_nz = 0;
            st = ttl_pkg::ST_CODE;
          end else begin
            emit(ttl_pkg::K_TEXTB, "{", 0);
            emit(ttl_pkg::K_TEXTB, c, 0);
            text_nz = 1;
            st = ttl_pkg::ST_TEXT;
          end
        end
        ttl_pkg::ST_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == "_") ident_feed(c);
          else begin
            emit(ident_kind(), 0, 0);
            code_char(c);
          end
        end
        ttl_pkg::ST_NUMBER: begin
          if (is_digit(c)) number_feed(c - "0");
          else begin
            emit(ttl_pkg::K_NUM, 0, num_acc);
            num_acc = 0;
            code_char(c);
          end
        end
        ttl_pkg::ST_STRING: begin
          if (c == "\"") begin
            emit(ttl_pkg::K_STREND, 0, 0);
            st = ttl_pkg::ST_CODE;
          end else emit(ttl_pkg::K_STRB, c, 0);
        end
        ttl_pkg::ST_LBRACE: begin
          emit(c == "{" ? ttl_pkg::K_DLBR : (c == "%" ? ttl_pkg::K_LBPCT : ttl_pkg::K_LBR),
               0, 0);
          st = ttl_pkg::ST_CODE;
        end
        ttl_pkg::ST_RBRACE: begin
          if (c == "}") begin
            text_nz = 0;
            st = ttl_pkg::ST_TEXT;
          end else begin
            emit(ttl_pkg::K_RBR, 0, 0);
            code_char(c);
          end
        end
        ttl_pkg::ST_DOT: begin
          emit(c == "." ? ttl_pkg::K_RANGE : ttl_pkg::K_ERR, 0, 0);
          st = ttl_pkg::ST_CODE;
        end
        ttl_pkg::ST_EQ:   pair(c, "=", ttl_pkg::K_EQEQ, ttl_pkg::K_ERR);
        ttl_pkg::ST_BANG: pair(c, "=", ttl_pkg::K_NE, ttl_pkg::K_ERR);
        ttl_pkg::ST_LT:   pair(c, "=", ttl_pkg::K_LE, ttl_pkg::K_LT);
        ttl_pkg::ST_GT:   pair(c, "=", ttl_pkg::K_GE, ttl_pkg::K_GT);
        ttl_pkg::ST_AMP:  pair(c, "&", ttl_pkg::K_AND, ttl_pkg::K_ERR);
        ttl_pkg::ST_BAR:  pair(c, "|", ttl_pkg::K_OR, ttl_pkg::K_ERR);
        default: code_char(c);
      endcase
    end
    for (int k = 0; k < n_res; k++) begin
      t.kind = r_kind[k];
      t.tb   = r_byte[k];
      t.num  = r_num[k];
      t.ln   = line_cnt;
      t.el   = err_line;
      t.last = (k == n_res - 1);
      token_q.push_back(t);
    end
    if (eoi) lexer_reset();
  endtask

  task automatic chk(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tok_t t;
    if (!rst_ni) begin
      lexer_reset();
      token_q.delete();
      errs = 0;
    end else begin
      if (in_m.valid && in_m.ready) lex_word(in_m.ch, in_m.end_of_input);
      if (out_m.valid && out_m.ready) begin
        if (token_q.size() == 0) begin
          $error("result word with nothing expected, kind %0d", out_m.kind);
          errs++;
        end else begin
          t = token_q.pop_front();
          chk("kind", t.kind, out_m.kind);
          chk("text_byte", t.tb, out_m.text_byte);
          chk("number_value", t.num, out_m.number_value);
          chk("line_number", t.ln, out_m.line_number);
          chk("error_line", t.el, out_m.error_line);
          chk("last", t.last, out_m.last);
        end
      end
    end
    err_cnt_o = errs;
    pending_o = token_q.size();
  end
endmodule

// File: tb/tb_template_token_lexer_top.sv
// template token lexer testbench top: clock, reset, template stimulus, verdict
// depends on ttl_pkg, ttl_if, ttl_checker and template_token_lexer_top
module tb_template_token_lexer_top;
  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  int   sent;
  int   burst_left;
  int   rx_cyc;
  bit   drained;

  ttl_in_if  in_w ();
  ttl_out_if out_w ();

  template_token_lexer_top uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w), .out_o(out_w));
  ttl_checker chk_u (.clk_i(clk_i), .rst_ni(rst_ni), .in_m(in_w), .out_m(out_w),
                     .err_cnt_o(err_cnt), .pending_o(pending));

  string code_toks [] = '{"if", "endif", "else", "for", "in", "endfor", "include",
    "blockprint", "menuprint", "block", "endblock", "x1_y", "abcdefghijklmnopq", "ifx",
    "0", "12", "4294967295", "99999999999", "+", "-", "*", "/", "%", "&&", "||", "==",
    "!=", "<", "<=", ">", ">=", "(", ")", "[", "]", "..", ".x", "{%", "{{", "{x", "=a",
    "!a", "&a", "|a", "\"str\"", "\"\"", "}a", "_", ",", ";", "~"};

  initial begin
    clk_i = 0;
    forever begin
      #5 clk_i = 1;
      #5 clk_i = 0;
    end
  end

  // receiver stall pattern: free-running stretches, light and heavy stalls
  initial out_w.ready = 0;
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 80) % 3)
      0:       out_w.ready <= 1'b1;
      1:       out_w.ready <= ($urandom_range(0, 3) != 0);
      default: out_w.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic put(logic [7:0] c, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_w.valid        <= 1'b1;
    in_w.ch           <= c;
    in_w.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_w.ready);
    sent++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endtask

  task automatic text_run();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == "{" && $urandom_range(0, 1)) put_str("{a");
      else if (b != "{") put(b, 1'b0);
    end
  endtask

  task automatic code_part();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b0);
      else put_str(code_toks[$urandom_range(0, code_toks.size() - 1)]);
      put($urandom_range(0, 3) == 0 ? 8'd10 : 8'd32, 1'b0);
    end
  endtask

  initial begin
    rx_cyc            = 0;
    sent              = 0;
    burst_left        = 0;
    drained           = 0;
    rst_ni            = 0;
    in_w.valid        = 0;
    in_w.ch           = 0;
    in_w.end_of_input = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    put_str("a{b{{if endblocks 4294967296\"q\n\"..<x}z}}\n");
    put(8'd0, 1'b1);
    put_str("{{\"ab");
    put(8'd0, 1'b1);
    put_str("{");
    put(8'd0, 1'b1);

    while (sent < 235) begin
      text_run();
      put_str("{{");
      code_part();
      case ($urandom_range(0, 5))
        0: put(8'd0, 1'b1);
        1: begin
          put_str(code_toks[$urandom_range(0, code_toks.size() - 1)]);
          put(8'd0, 1'b1);
        end
        default: begin
          put_str("}}");
          text_run();
          if ($urandom_range(0, 3) == 0) put(8'd0, 1'b1);
        end
      endcase
      if (!drained && sent > 120) begin
        drained = 1;
        in_w.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    put(8'd0, 1'b1);
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_template_token_lexer_top: done, clean");
    else $display("tb_template_token_lexer_top: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_template_token_lexer_top: done, errors");
    $finish;
  end
endmodule

// File: files.f
rtl/ttl_pkg.sv
rtl/ttl_if.sv
rtl/ttl_front.sv
rtl/ttl_fifo.sv
rtl/ttl_back.sv
rtl/template_token_lexer_top.sv
tb/ttl_checker.sv
tb/tb_template_token_lexer_top.sv
